>>> sv/dlts_pkg.sv
// shared types and constants of the delta list task scheduler
// no dependencies; imported by the controller, the top level and the testbench

package dlts_pkg;

  // default sizes for the top-level parameters
  localparam int unsigned EntriesDef   = 16;
  localparam int unsigned DelayBitsDef = 16;
  localparam int unsigned IdBitsDef    = 8;

  // request kinds carried in the slave tuser
  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_DISPATCH = 2'd2
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // one result transfer
  typedef struct packed {
    status_e    status;
    logic       dispatched;
    logic [7:0] ready_task_id;
  } res_t;

endpackage

>>> sv/delta_list_task_scheduler.sv
// top level of the delta list task scheduler: stream ports, memories, result register
// depends on dlts_pkg, dlts_ctrl, dlts_link and dlts_ram

// A pool of ENTRIES task slots is linked into a free list, a ready FIFO and a
// delay list kept in deadline order with per-entry delays relative to the
// predecessor. Each request (add, tick, dispatch) gives exactly one result.
// Requests are handled one at a time; the link, delta and task memories have
// one read port, so the delay list is walked one entry per clock. An add on a
// full pool, a dispatch on an empty ready FIFO, an unused request code and a
// tick on an empty delay list go straight to the result; an add with a delay
// walks the delay list to its insertion point, and a tick moves each task that
// expires to the ready FIFO. s_axis_tready comes back at the same edge that
// raises m_axis_tvalid. The result sits in an output register, so the next
// request can enter while the previous result waits on m_axis_tready; a
// second finished result waits inside until that register frees up. No
// memory clearing is needed after reset.

module delta_list_task_scheduler
  import dlts_pkg::*;
#(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned DELAY_BITS = DelayBitsDef,
  parameter int unsigned ID_BITS    = IdBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] task_id, [23:8] delay_ticks
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] ready_task_id
  output logic [2:0]  m_axis_tuser    // [1:0] status, [2] dispatched
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned IW = $clog2(ENTRIES + 1);

  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic [AW-1:0]         rd_addr;
  logic                  link_we;
  logic [AW-1:0]         link_waddr;
  logic [IW-1:0]         link_wdata, link_rdata;
  logic                  delta_we;
  logic [AW-1:0]         delta_waddr;
  logic [DELAY_BITS-1:0] delta_wdata, delta_rdata;
  logic                  task_we;
  logic [AW-1:0]         task_waddr;
  logic [ID_BITS-1:0]    task_wdata, task_rdata;

  logic out_valid_q;
  res_t out_q;

  dlts_ctrl #(
    .ENTRIES    (ENTRIES),
    .DELAY_BITS (DELAY_BITS),
    .ID_BITS    (ID_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .req_type_i    (s_axis_tuser),
    .task_id_i     (s_axis_tdata[7:0]),
    .delay_ticks_i (s_axis_tdata[23:8]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .rd_addr_o     (rd_addr),
    .link_we_o     (link_we),
    .link_waddr_o  (link_waddr),
    .link_wdata_o  (link_wdata),
    .link_rdata_i  (link_rdata),
    .delta_we_o    (delta_we),
    .delta_waddr_o (delta_waddr),
    .delta_wdata_o (delta_wdata),
    .delta_rdata_i (delta_rdata),
    .task_we_o     (task_we),
    .task_waddr_o  (task_waddr),
    .task_wdata_o  (task_wdata),
    .task_rdata_i  (task_rdata)
  );

  // next pointers
  dlts_link #(
    .ENTRIES (ENTRIES)
  ) u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  // relative delays
  dlts_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (DELAY_BITS)
  ) u_delta (
    .clk_i   (clk_i),
    .we_i    (delta_we),
    .waddr_i (delta_waddr),
    .wdata_i (delta_wdata),
    .raddr_i (rd_addr),
    .rdata_o (delta_rdata)
  );

  // task handles
  dlts_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ID_BITS)
  ) u_task (
    .clk_i   (clk_i),
    .we_i    (task_we),
    .waddr_i (task_waddr),
    .wdata_i (task_wdata),
    .raddr_i (rd_addr),
    .rdata_o (task_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.ready_task_id;
  assign m_axis_tuser  = {out_q.dispatched, out_q.status};

endmodule

>>> sv/dlts_ram.sv
// simple dual-port synchronous ram, one write and one registered read per cycle
// write data is forwarded to the read port on a same-address collision

module dlts_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read with write-through on collision
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/dlts_link.sv
// link memory: next pointer of every pool entry
// built on dlts_ram; per-entry valid bits give the reset free chain i -> i+1

module dlts_link #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [$clog2(ENTRIES)-1:0]          waddr_i,
  input  logic [$clog2(ENTRIES+1)-1:0]        wdata_i,
  input  logic [$clog2(ENTRIES)-1:0]          raddr_i,
  output logic [$clog2(ENTRIES+1)-1:0]        rdata_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned IW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] valid_q;
  logic               rvalid_q;
  logic [AW-1:0]      raddr_q;
  logic [IW-1:0]      ram_rdata;

  dlts_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // written-entry flags and read-side valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i] | (we_i && (waddr_i == raddr_i));
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_i;
  end

  // unwritten entries read as the initial free chain
  assign rdata_o = rvalid_q ? ram_rdata : (IW'(raddr_q) + IW'(1));

endmodule

>>> sv/dlts_ctrl.sv
// list sequencer: walks and relinks the free, ready and delay lists
// depends on dlts_pkg; drives the link, delta and task memories

module dlts_ctrl
  import dlts_pkg::*;
#(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned DELAY_BITS = DelayBitsDef,
  parameter int unsigned ID_BITS    = IdBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    task_id_i,
  input  logic [15:0]                   delay_ticks_i,
  // result side
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output res_t                          res_o,
  // shared read address of all memories
  output logic [$clog2(ENTRIES)-1:0]    rd_addr_o,
  // link memory
  output logic                          link_we_o,
  output logic [$clog2(ENTRIES)-1:0]    link_waddr_o,
  output logic [$clog2(ENTRIES+1)-1:0]  link_wdata_o,
  input  logic [$clog2(ENTRIES+1)-1:0]  link_rdata_i,
  // delta memory
  output logic                          delta_we_o,
  output logic [$clog2(ENTRIES)-1:0]    delta_waddr_o,
  output logic [DELAY_BITS-1:0]         delta_wdata_o,
  input  logic [DELAY_BITS-1:0]         delta_rdata_i,
  // task memory
  output logic                          task_we_o,
  output logic [$clog2(ENTRIES)-1:0]    task_waddr_o,
  output logic [ID_BITS-1:0]            task_wdata_o,
  input  logic [ID_BITS-1:0]            task_rdata_i
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned IW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] NIL = IW'(ENTRIES);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_ADD_POP = 10'b00_0000_0010,
    S_WALK    = 10'b00_0000_0100,
    S_INS_A   = 10'b00_0000_1000,
    S_INS_B   = 10'b00_0001_0000,
    S_APP_A   = 10'b00_0010_0000,
    S_APP_B   = 10'b00_0100_0000,
    S_TICK    = 10'b00_1000_0000,
    S_DSP     = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // list anchors
  logic [IW-1:0] free_head_q, free_head_d, free_tail_q, free_tail_d;
  logic [IW-1:0] ready_head_q, ready_head_d, ready_tail_q, ready_tail_d;
  logic [IW-1:0] wait_head_q, wait_head_d, wait_tail_q, wait_tail_d;

  // per-request working registers
  logic [IW-1:0]         r_q, r_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic [DELAY_BITS-1:0] t_q, t_d;
  logic [DELAY_BITS-1:0] dp_q, dp_d;
  logic [IW-1:0]         p_q, p_d, prev_q, prev_d;
  logic [IW-1:0]         guard_q, guard_d;
  logic                  first_q, first_d;
  logic [IW-1:0]         app_e_q, app_e_d, otail_q, otail_d;
  logic                  app_free_q, app_free_d;
  logic                  app_tick_q, app_tick_d;
  res_t                  res_q, res_d;

  logic [IW-1:0]         rd_idx;
  logic [DELAY_BITS-1:0] tick_dec;
  logic                  walk_on;
  logic                  head_zero;
  logic [IW-1:0]         cur_tail;

  assign tick_dec   = delta_rdata_i - DELAY_BITS'(1);
  assign walk_on    = (guard_q < IW'(ENTRIES)) && (t_q > delta_rdata_i);
  assign head_zero  = first_q ? (tick_dec == '0) : (delta_rdata_i == '0);
  assign cur_tail   = app_free_q ? free_tail_q : ready_tail_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign rd_addr_o   = rd_idx[AW-1:0];

  // sequencer
  always_comb begin
    state_d      = state_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    ready_head_d = ready_head_q;
    ready_tail_d = ready_tail_q;
    wait_head_d  = wait_head_q;
    wait_tail_d  = wait_tail_q;
    r_d          = r_q;
    id_d         = id_q;
    t_d          = t_q;
    dp_d         = dp_q;
    p_d          = p_q;
    prev_d       = prev_q;
    guard_d      = guard_q;
    first_d      = first_q;
    app_e_d      = app_e_q;
    otail_d      = otail_q;
    app_free_d   = app_free_q;
    app_tick_d   = app_tick_q;
    res_d        = res_q;
    rd_idx       = wait_head_q;
    link_we_o    = 1'b0;
    link_waddr_o = r_q[AW-1:0];
    link_wdata_o = NIL;
    delta_we_o   = 1'b0;
    delta_waddr_o = r_q[AW-1:0];
    delta_wdata_o = t_q;
    task_we_o    = 1'b0;
    task_waddr_o = r_q[AW-1:0];
    task_wdata_o = id_q;

    unique case (state_q)
      S_IDLE: begin
        unique case (req_type_i)
          REQ_ADD:      rd_idx = free_head_q;
          REQ_DISPATCH: rd_idx = ready_head_q;
          default:      rd_idx = wait_head_q;
        endcase
        if (in_valid_i) begin
          res_d   = '{status: ST_OK, dispatched: 1'b0, ready_task_id: 8'd0};
          r_d     = free_head_q;
          id_d    = ID_BITS'(task_id_i);
          t_d     = DELAY_BITS'(delay_ticks_i);
          first_d = 1'b1;
          state_d = S_DONE;
          unique case (req_type_i)
            REQ_ADD: begin
              if (free_head_q == NIL) begin
                res_d.status = ST_FULL;
              end else begin
                state_d = S_ADD_POP;
              end
            end
            REQ_TICK: begin
              if (wait_head_q != NIL) begin
                state_d = S_TICK;
              end
            end
            REQ_DISPATCH: begin
              if (ready_head_q == NIL) begin
                res_d.status = ST_EMPTY;
              end else begin
                state_d = S_DSP;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // unlink from the free list, store the task id
      S_ADD_POP: begin
        free_head_d = link_rdata_i;
        if (link_rdata_i == NIL) begin
          free_tail_d = NIL;
        end
        task_we_o = 1'b1;
        if (t_q == '0) begin
          app_e_d    = r_q;
          app_free_d = 1'b0;
          app_tick_d = 1'b0;
          state_d    = S_APP_A;
        end else begin
          p_d     = wait_head_q;
          prev_d  = NIL;
          guard_d = '0;
          rd_idx  = wait_head_q;
          state_d = (wait_head_q == NIL) ? S_INS_A : S_WALK;
        end
      end

      // one delay entry per cycle
      S_WALK: begin
        if (walk_on) begin
          t_d     = t_q - delta_rdata_i;
          prev_d  = p_q;
          p_d     = link_rdata_i;
          guard_d = guard_q + IW'(1);
          rd_idx  = link_rdata_i;
          if (link_rdata_i == NIL) begin
            state_d = S_INS_A;
          end
        end else begin
          dp_d    = delta_rdata_i;
          state_d = S_INS_A;
        end
      end

      // new entry points at its successor
      S_INS_A: begin
        link_we_o     = 1'b1;
        link_wdata_o  = p_q;
        delta_we_o    = 1'b1;
        if (prev_q == NIL) begin
          wait_head_d = r_q;
        end
        if (p_q == NIL) begin
          wait_tail_d = r_q;
        end
        state_d = ((prev_q != NIL) || (p_q != NIL)) ? S_INS_B : S_DONE;
      end

      // predecessor link and successor delta
      S_INS_B: begin
        link_we_o     = (prev_q != NIL);
        link_waddr_o  = prev_q[AW-1:0];
        link_wdata_o  = r_q;
        delta_we_o    = (p_q != NIL);
        delta_waddr_o = p_q[AW-1:0];
        delta_wdata_o = dp_q - t_q;
        state_d       = S_DONE;
      end

      // tail append, first half: terminate the entry, move the anchors
      S_APP_A: begin
        link_we_o    = 1'b1;
        link_waddr_o = app_e_q[AW-1:0];
        link_wdata_o = NIL;
        otail_d      = cur_tail;
        if (app_free_q) begin
          if (free_tail_q == NIL) begin
            free_head_d = app_e_q;
          end
          free_tail_d = app_e_q;
        end else begin
          if (ready_tail_q == NIL) begin
            ready_head_d = app_e_q;
          end
          ready_tail_d = app_e_q;
        end
        if (cur_tail != NIL) begin
          state_d = S_APP_B;
        end else if (app_tick_q && (wait_head_q != NIL)) begin
          state_d = S_TICK;
        end else begin
          state_d = S_DONE;
        end
      end

      // tail append, second half: old tail points at the entry
      S_APP_B: begin
        link_we_o    = 1'b1;
        link_waddr_o = otail_q[AW-1:0];
        link_wdata_o = app_e_q;
        if (app_tick_q && (wait_head_q != NIL)) begin
          state_d = S_TICK;
        end else begin
          state_d = S_DONE;
        end
      end

      // decrement the head once, then move expired heads
      S_TICK: begin
        first_d = 1'b0;
        if (first_q) begin
          delta_we_o    = 1'b1;
          delta_waddr_o = wait_head_q[AW-1:0];
          delta_wdata_o = tick_dec;
        end
        if (head_zero) begin
          wait_head_d = link_rdata_i;
          if (link_rdata_i == NIL) begin
            wait_tail_d = NIL;
          end
          app_e_d    = wait_head_q;
          app_free_d = 1'b0;
          app_tick_d = 1'b1;
          state_d    = S_APP_A;
        end else begin
          state_d = S_DONE;
        end
      end

      // pop the ready head and return it to the pool
      S_DSP: begin
        ready_head_d = link_rdata_i;
        if (link_rdata_i == NIL) begin
          ready_tail_d = NIL;
        end
        res_d.dispatched    = 1'b1;
        res_d.ready_task_id = 8'(task_rdata_i);
        app_e_d    = ready_head_q;
        app_free_d = 1'b1;
        app_tick_d = 1'b0;
        state_d    = S_APP_A;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_head_q  <= '0;
      free_tail_q  <= IW'(ENTRIES - 1);
      ready_head_q <= NIL;
      ready_tail_q <= NIL;
      wait_head_q  <= NIL;
      wait_tail_q  <= NIL;
      first_q      <= 1'b0;
      app_free_q   <= 1'b0;
      app_tick_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      ready_head_q <= ready_head_d;
      ready_tail_q <= ready_tail_d;
      wait_head_q  <= wait_head_d;
      wait_tail_q  <= wait_tail_d;
      first_q      <= first_d;
      app_free_q   <= app_free_d;
      app_tick_q   <= app_tick_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    id_q    <= id_d;
    t_q     <= t_d;
    dp_q    <= dp_d;
    p_q     <= p_d;
    prev_q  <= prev_d;
    guard_q <= guard_d;
    app_e_q <= app_e_d;
    otail_q <= otail_d;
    res_q   <= res_d;
  end

  // list anchors stay paired between requests
  a_free_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((free_head_q == NIL) == (free_tail_q == NIL)))
    else $error("free list head and tail disagree on emptiness");

  a_ready_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((ready_head_q == NIL) == (ready_tail_q == NIL)))
    else $error("ready list head and tail disagree on emptiness");

  a_wait_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((wait_head_q == NIL) == (wait_tail_q == NIL)))
    else $error("delay list head and tail disagree on emptiness");

  // the second insert step always has a neighbor to fix up
  a_ins_neighbor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_B) |-> ((prev_q != NIL) || (p_q != NIL)))
    else $error("insert fix-up without predecessor or successor");

  // an accepted add on an empty pool reports full right away
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_ADD) && (free_head_q == NIL))
    |=> ((state_q == S_DONE) && (res_q.status == ST_FULL)))
    else $error("add on exhausted pool not rejected");

endmodule

>>> tb/delta_list_task_scheduler_tb.sv
// self-checking testbench of the delta list task scheduler: stream stimulus and scoreboard
// depends on dlts_pkg and delta_list_task_scheduler; predicts every result from its own list model
`timescale 1ns / 100ps

module delta_list_task_scheduler_tb
  import dlts_pkg::*;
();

  localparam int unsigned SLOTS        = EntriesDef;
  localparam logic [4:0]  NIL          = 5'(SLOTS);
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int          RAND_ITEMS   = 750;
  localparam int          LONG_HOLD    = 400;
  localparam int          DRAIN_CYCLES = 40;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_e;

  // list model of the scheduler plus the store of results still to come
  class sched_tracker;
    logic [4:0]  link_of  [SLOTS];
    logic [15:0] delta_of [SLOTS];
    logic [7:0]  id_of    [SLOTS];
    logic [4:0]  free_hd, free_tl, ready_hd, ready_tl, wait_hd, wait_tl;
    res_t        due_results[$];
    int          errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        link_of[i]  = 5'(i + 1);
        delta_of[i] = '0;
        id_of[i]    = '0;
      end
      free_hd  = '0;
      free_tl  = 5'(SLOTS - 1);
      ready_hd = NIL;
      ready_tl = NIL;
      wait_hd  = NIL;
      wait_tl  = NIL;
      errors   = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void ready_append(logic [4:0] e);
      link_of[e] = NIL;
      if (ready_tl == NIL) ready_hd = e;
      else link_of[ready_tl] = e;
      ready_tl = e;
    endfunction

    // apply one accepted request to the model and queue its result
    function void accept_request(logic [1:0] req, logic [7:0] id, logic [15:0] dly);
      res_t        r;
      logic [4:0]  e, p, prv;
      logic [15:0] t;
      int          guard;
      r.status        = ST_OK;
      r.dispatched    = 1'b0;
      r.ready_task_id = '0;
      case (req)
        REQ_ADD: begin
          if (free_hd == NIL) begin
            r.status = ST_FULL;
          end else begin
            e = free_hd;
            free_hd = link_of[e];
            if (free_hd == NIL) free_tl = NIL;
            id_of[e] = id;
            if (dly == '0) begin
              ready_append(e);
            end else begin
              // walk the delay list until the cumulative delay reaches the request
              t = dly;
              p = wait_hd;
              prv = NIL;
              guard = 0;
              while (p != NIL && guard < SLOTS && t > delta_of[p]) begin
                t = t - delta_of[p];
                prv = p;
                p = link_of[p];
                guard++;
              end
              delta_of[e] = t;
              link_of[e] = p;
              if (prv == NIL) wait_hd = e;
              else link_of[prv] = e;
              if (p == NIL) wait_tl = e;
              else delta_of[p] = delta_of[p] - t;
            end
          end
        end
        REQ_TICK: begin
          if (wait_hd != NIL) begin
            delta_of[wait_hd] = delta_of[wait_hd] - 16'd1;
            // every expired head moves to the ready fifo
            while (wait_hd != NIL && delta_of[wait_hd] == '0) begin
              e = wait_hd;
              wait_hd = link_of[e];
              if (wait_hd == NIL) wait_tl = NIL;
              ready_append(e);
            end
          end
        end
        REQ_DISPATCH: begin
          if (ready_hd == NIL) begin
            r.status = ST_EMPTY;
          end else begin
            e = ready_hd;
            ready_hd = link_of[e];
            if (ready_hd == NIL) ready_tl = NIL;
            link_of[e] = NIL;
            if (free_tl == NIL) free_hd = e;
            else link_of[free_tl] = e;
            free_tl = e;
            r.dispatched    = 1'b1;
            r.ready_task_id = id_of[e];
          end
        end
        default: ;
      endcase
      due_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare one result transfer with the oldest queued result
    task check_result(logic [7:0] data, logic [2:0] user);
      res_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing queued (tdata %0h tuser %0h)",
                                  data, user));
        return;
      end
      want = due_results.pop_front();
      if (user[1:0] !== want.status)
        report_mismatch($sformatf("status %0d, wanted %0d", user[1:0], want.status));
      if (user[2] !== want.dispatched)
        report_mismatch($sformatf("dispatched %0b, wanted %0b", user[2], want.dispatched));
      if (data !== want.ready_task_id)
        report_mismatch($sformatf("ready_task_id %0h, wanted %0h", data,
                                  want.ready_task_id));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  sched_tracker tracker;
  bit           hold_req = 1'b0;
  bit           tx_calm  = 1'b0;
  bit           rx_calm  = 1'b0;

  delta_list_task_scheduler dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // gap lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // delays: many zero or short so tasks expire, some longer
  function automatic logic [15:0] pick_delay();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return '0;
    if (roll < 80) return 16'($urandom_range(1, 12));
    if (roll < 95) return 16'($urandom_range(13, 80));
    return 16'($urandom_range(81, 200));
  endfunction

  // offer one request, wait for its transfer, then maybe idle
  task automatic send_request(logic [1:0] req, logic [7:0] id, logic [15:0] dly);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {dly, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.accept_request(req, id, dly);
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every queued result has arrived
  task automatic drain_results();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // result side: check each transfer and pace tready
  initial begin
    int stall;
    bit held;
    stall = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_req && !held) begin
        stall = LONG_HOLD;
        held  = 1'b1;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_calm) stall = pick_gap();
      end
    end
  end

  // request side: directed cases, then random segments
  initial begin
    seg_e        seg;
    int          seg_left, roll, add_pct, tick_pct, disp_pct;
    logic [1:0]  req;
    logic [15:0] dly;
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty ready fifo, empty delay list, unused request code
    send_request(REQ_DISPATCH, 8'hff, 16'hffff);
    send_request(REQ_TICK, 8'h00, 16'h0000);
    send_request(REQ_UNUSED, 8'hff, 16'hffff);
    // immediate tasks leave in fifo order
    send_request(REQ_ADD, 8'hff, 16'h0000);
    send_request(REQ_ADD, 8'h00, 16'h0000);
    send_request(REQ_DISPATCH, 8'h00, 16'h0000);
    send_request(REQ_DISPATCH, 8'h00, 16'h0000);
    // largest delays, the second inserted before the first
    send_request(REQ_ADD, 8'ha5, 16'hffff);
    send_request(REQ_ADD, 8'h5a, 16'h8000);
    // equal deadlines expire on the same tick
    send_request(REQ_ADD, 8'h11, 16'd3);
    send_request(REQ_ADD, 8'h12, 16'd3);
    repeat (3) send_request(REQ_TICK, 8'h00, 16'h0000);
    send_request(REQ_DISPATCH, 8'h00, 16'h0000);
    send_request(REQ_DISPATCH, 8'h00, 16'h0000);
    // insertion at the head, again at the head and then in the middle
    send_request(REQ_ADD, 8'h13, 16'd5);
    send_request(REQ_ADD, 8'h14, 16'd2);
    send_request(REQ_ADD, 8'h15, 16'd4);
    // fill the pool, then one add too many
    for (int i = 0; i < SLOTS - 5; i++) send_request(REQ_ADD, 8'(8'h20 + i), 16'h0000);
    send_request(REQ_ADD, 8'h7e, 16'h0001);

    seg_left = 0;
    seg = SEG_MIX;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 200) begin
        // long receiver hold while the sender keeps pushing
        hold_req = 1'b1;
        tx_calm = 1'b1;
        seg = SEG_MIX;
        seg_left = 60;
      end else if (n == 450) begin
        drain_results();
      end
      if (seg_left == 0) begin
        seg = seg_e'($urandom_range(0, 2));
        seg_left = $urandom_range(12, 40);
        tx_calm = ($urandom_range(0, 5) == 0);
        rx_calm = ($urandom_range(0, 5) == 0);
      end
      seg_left--;
      case (seg)
        SEG_FILL:  begin add_pct = 70; tick_pct = 15; disp_pct = 10; end
        SEG_DRAIN: begin add_pct = 15; tick_pct = 45; disp_pct = 35; end
        default:   begin add_pct = 35; tick_pct = 30; disp_pct = 30; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < add_pct) req = REQ_ADD;
      else if (roll < add_pct + tick_pct) req = REQ_TICK;
      else if (roll < add_pct + tick_pct + disp_pct) req = REQ_DISPATCH;
      else req = REQ_UNUSED;
      dly = (req == REQ_ADD) ? pick_delay() : 16'($urandom);
      send_request(req, 8'($urandom_range(0, 255)), dly);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
